/* rtl/core/grs_pkg.sv */
// grs_pkg: shared constants and control structs for the group reverse stream.
// No dependencies; used by grs_front, grs_back and the top level.
`default_nettype none

package grs_pkg;

	localparam int MAX_GROUP_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int CFG_W          = 5;

	// run descriptor flags, front to back
	typedef struct packed {
		logic bank;
		logic rev;
		logic eos;
	} cmd_flags_t;

	// bank release, back to front
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

`default_nettype wire

/* rtl/core/grs_front.sv */
// grs_front: word intake, group size register, fill count and bank select.
// Writes words into the group buffer and queues one descriptor per run.
// Depends on grs_pkg.
`default_nettype none

module grs_front #(
	parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF,
	localparam int CW = $clog2(MAX_GROUP + 1),
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [grs_pkg::CFG_W-1:0]    cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [DATA_WIDTH-1:0]        in_value,
	input  wire                         in_eos,
	output logic                        mem_we,
	output logic [AW:0]                 mem_addr,
	output logic [DATA_WIDTH-1:0]       mem_data,
	output logic                        q_push,
	input  wire                         q_full,
	output grs_pkg::cmd_flags_t         q_flags,
	output logic [CW-1:0]               q_count,
	input  wire grs_pkg::rel_t          rel
);

	logic [grs_pkg::CFG_W-1:0] group_size_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             eff_g;
	logic [CW-1:0]             n;
	logic                      wr_bank_q;
	logic [1:0]                busy_q;
	logic [1:0]                busy_d;
	logic                      fire;
	logic                      rev;
	logic                      trig;

	always_comb begin
		if (group_size_q == '0) begin
			eff_g = CW'(1);
		end else if (32'(group_size_q) > MAX_GROUP) begin
			eff_g = CW'(MAX_GROUP);
		end else begin
			eff_g = CW'(group_size_q);
		end
	end

	assign in_ready = !busy_q[wr_bank_q] && !q_full;
	assign fire     = in_valid && in_ready;
	assign n        = fill_q + CW'(1);
	assign rev      = (n >= eff_g);
	assign trig     = rev || in_eos;

	assign mem_we   = fire;
	assign mem_addr = {wr_bank_q, AW'(fill_q)};
	assign mem_data = in_value;

	assign q_push       = fire && trig;
	assign q_flags.bank = wr_bank_q;
	assign q_flags.rev  = rev;
	assign q_flags.eos  = in_eos;
	assign q_count      = n;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (q_push) begin
			busy_d[wr_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grs_pkg::CFG_W'(1);
			fill_q       <= '0;
			wr_bank_q    <= 1'b0;
			busy_q       <= '0;
		end else begin
			if (cfg_we) begin
				group_size_q <= cfg_data;
			end
			if (fire) begin
				if (trig) begin
					fill_q    <= '0;
					wr_bank_q <= !wr_bank_q;
				end else begin
					fill_q <= n;
				end
			end
			busy_q <= busy_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/grs_cmd_fifo.sv */
// grs_cmd_fifo: two-entry descriptor queue between front and back.
// Generic width; no package dependency.
`default_nettype none

module grs_cmd_fifo #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire [W-1:0]  din,
	output logic         full,
	input  wire          pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/grs_back.sv */
// grs_back: ping-pong group buffer and drain sequencer.
// Unless stalled, reads a word a cycle into the output register, full runs reversed.
// Depends on grs_pkg.
`default_nettype none

module grs_back #(
	parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF,
	localparam int CW = $clog2(MAX_GROUP + 1),
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         mem_we,
	input  wire [AW:0]                  mem_addr,
	input  wire [DATA_WIDTH-1:0]        mem_data,
	input  wire                         q_empty,
	output logic                        q_pop,
	input  wire grs_pkg::cmd_flags_t    q_flags,
	input  wire [CW-1:0]                q_count,
	output grs_pkg::rel_t               rel,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [DATA_WIDTH-1:0]       out_value,
	output logic                        out_last,
	output logic                        out_done
);

	localparam int MEM_D = 2 << AW;

	typedef enum logic {IDLE, RUN} state_t;

	state_t                  state_q;
	grs_pkg::cmd_flags_t     flags_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           idx;
	logic [DATA_WIDTH-1:0]   mem_q [MEM_D];
	logic [DATA_WIDTH-1:0]   data_s1;
	logic                    v_s1;
	logic                    last_s1;
	logic                    done_s1;
	logic                    adv;
	logic                    issue;
	logic                    last_k;
	logic                    load;

	assign adv    = !v_s1 || out_ready;
	assign issue  = (state_q == RUN) && adv;
	assign last_k = (k_q == cnt_q - CW'(1));
	assign load   = !q_empty && ((state_q == IDLE) || (issue && last_k));
	assign q_pop  = load;
	assign idx    = flags_q.rev ? (cnt_q - CW'(1) - k_q) : k_q;

	assign rel.valid = issue && last_k;
	assign rel.bank  = flags_q.bank;

	assign out_valid = v_s1;
	assign out_value = data_s1;
	assign out_last  = last_s1;
	assign out_done  = done_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1 <= mem_q[{flags_q.bank, idx[AW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			flags_q <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			if (adv) begin
				v_s1    <= issue;
				last_s1 <= last_k;
				done_s1 <= last_k && flags_q.eos;
			end
			if (load) begin
				flags_q <= q_flags;
				cnt_q   <= q_count;
				k_q     <= '0;
				state_q <= RUN;
			end else if (issue) begin
				if (last_k) begin
					state_q <= IDLE;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/group_reverse_stream.sv */
// group_reverse_stream: top level; front intake, descriptor queue, drain back end.
// Depends on grs_pkg, grs_front, grs_cmd_fifo, grs_back.
//
//  port group   dir  tdata                         tlast            tuser
//  s_axis       in   value                         end_of_sequence  -
//  m_axis       out  value_res                     last_of_run      sequence_done
//  cfg          in   cfg_data = group_size, written when cfg_we
//
// Intake takes one word a cycle while its buffer bank is free; two banks let a
// group fill while the previous one drains. A bank takes new words from the cycle
// after its last word is read. When the back end is idle, the run that a word
// completes is queued as a descriptor, loaded into the back end and then read
// into the output register. Reset is asynchronous and clears all control state;
// buffer contents are not cleared.
// A stalled m_axis holds its word and stalls the drain; intake stops only when
// both banks are waiting to drain.
`default_nettype none

module group_reverse_stream #(
	parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF,
	localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [grs_pkg::CFG_W-1:0]  cfg_data,
	input  wire                       s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire [TDATA_W-1:0]         s_axis_tdata,   // value
	input  wire                       s_axis_tlast,   // end_of_sequence
	output logic                      m_axis_tvalid,
	input  wire                       m_axis_tready,
	output logic [TDATA_W-1:0]        m_axis_tdata,   // value_res
	output logic                      m_axis_tlast,   // last_of_run
	output logic                      m_axis_tuser    // sequence_done
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int QW = $bits(grs_pkg::cmd_flags_t) + CW;

	logic                    mem_we;
	logic [AW:0]             mem_addr;
	logic [DATA_WIDTH-1:0]   mem_data;
	logic                    q_push;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_empty;
	grs_pkg::cmd_flags_t     wq_flags;
	logic [CW-1:0]           wq_count;
	grs_pkg::cmd_flags_t     rq_flags;
	logic [CW-1:0]           rq_count;
	logic [QW-1:0]           q_dout;
	grs_pkg::rel_t           rel;
	logic [DATA_WIDTH-1:0]   out_value;

	assign {rq_flags, rq_count} = q_dout;
	assign m_axis_tdata = TDATA_W'(out_value);

	grs_front #(
		.MAX_GROUP  (MAX_GROUP),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_value (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_eos   (s_axis_tlast),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_data (mem_data),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_flags  (wq_flags),
		.q_count  (wq_count),
		.rel      (rel)
	);

	grs_cmd_fifo #(
		.W (QW)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({wq_flags, wq_count}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	grs_back #(
		.MAX_GROUP  (MAX_GROUP),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_data  (mem_data),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_flags   (rq_flags),
		.q_count   (rq_count),
		.rel       (rel),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (out_value),
		.out_last  (m_axis_tlast),
		.out_done  (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* rtl/core/grs_checker.sv */
// grs_checker: port-level assertions on the output side of group_reverse_stream.
// Bound to the top level below; no package dependency.
`default_nettype none

module grs_checker #(
	parameter int TDATA_W = 16
) (
	input wire               clk,
	input wire               arst_n,
	input wire               m_axis_tvalid,
	input wire               m_axis_tready,
	input wire [TDATA_W-1:0] m_axis_tdata,
	input wire               m_axis_tlast,
	input wire               m_axis_tuser
);

	// sequence end only closes a run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("sequence_done without last_of_run");

	// nothing offered while held in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

endmodule

bind group_reverse_stream grs_checker #(
	.TDATA_W (TDATA_W)
) u_grs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
